FILE: design/bsf_pkg.sv
package bsf_pkg;

	// plane geometry defaults
	localparam int unsigned PLANE_BYTES_DEF   = 8192;
	localparam int unsigned MAX_ROW_BYTES_DEF = 64;

	// field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned XPOS_W  = 9;
	localparam int unsigned YPOS_W  = 8;
	localparam int unsigned SIDE_W  = 8;
	localparam int unsigned BADDR_W = 13;
	localparam int unsigned BPR_W   = 7;
	localparam int unsigned ROWS_W  = 9;
	localparam int unsigned CFG_W   = 9;
	localparam int unsigned CIDX_W  = 1;

	// derived column and row widths
	localparam int unsigned FCOL_W = XPOS_W - 3;
	localparam int unsigned LPX_W  = XPOS_W + 1;
	localparam int unsigned LCOL_W = LPX_W - 3;
	localparam int unsigned ROW_W  = ROWS_W;

	// command codes
	localparam logic [CMD_W-1:0] CMD_FILL  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_BYTES_PER_ROW = 1'd0;
	localparam logic [CIDX_W-1:0] REG_PLANE_ROWS    = 1'd1;

	// register reset values
	localparam logic [BPR_W-1:0]  BPR_RESET  = 7'd40;
	localparam logic [ROWS_W-1:0] ROWS_RESET = 9'd200;

	// masks
	localparam logic [BYTE_W-1:0] MASK_FULL = 8'hFF;

endpackage

FILE: design/bsf_plane_ram.sv
module bsf_plane_ram
	import bsf_pkg::*;
#(
	parameter int unsigned DEPTH  = PLANE_BYTES_DEF,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: design/bitplane_square_fill_top.sv
// Path from accept to rsp_valid: read via RDWAIT; clear sweeps all PLANE_BYTES entries;
//   empty fill or unused command goes to RESP; fill walks side * (last_col - first_col + 1)
//   bytes then DRAIN, one byte read-modify-write per cycle through the plane memory ports.
// One command is worked at a time; req_stall drops together with the result beat, so the
//   next beat can be taken in the same cycle that rsp_valid rises.
// Reset: registers to 40 bytes per row and 200 rows, then a sweep over all PLANE_BYTES
//   entries zeroes the plane while req_stall is held high (config writes are still taken).
module bitplane_square_fill_top
	import bsf_pkg::*;
#(
	parameter int unsigned PLANE_BYTES   = PLANE_BYTES_DEF,
	parameter int unsigned MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_wr_en,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	// command channel
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [XPOS_W-1:0]  x_pos,
	input  logic [YPOS_W-1:0]  y_pos,
	input  logic [SIDE_W-1:0]  side,
	input  logic [BADDR_W-1:0] byte_addr,
	// result channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [BYTE_W-1:0]  read_data,
	output logic               clipped
);

	localparam int unsigned AW = $clog2(PLANE_BYTES);
	localparam int unsigned STR_MAX = (MAX_ROW_BYTES > 127) ? 127 : MAX_ROW_BYTES;
	localparam logic [BPR_W-1:0] STR_CLAMP = BPR_W'(STR_MAX);
	localparam int unsigned LIN_W = $clog2(509 * STR_MAX + 97);
	localparam logic [AW-1:0] LAST_ENTRY = AW'(PLANE_BYTES - 1);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_FILL   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_RDWAIT = 3'd4;
	localparam logic [2:0] ST_CLEAR  = 3'd5;
	localparam logic [2:0] ST_RESP   = 3'd6;

	logic [2:0]         state_q;
	logic [BPR_W-1:0]   bpr_q;
	logic [ROWS_W-1:0]  rows_q;
	logic [AW-1:0]      clr_q;

	// fill walk state
	logic [BPR_W-1:0]   stride_q;
	logic [FCOL_W-1:0]  first_col_q;
	logic [LCOL_W-1:0]  last_col_q;
	logic [LCOL_W-1:0]  col_q;
	logic [ROW_W-1:0]   row_q;
	logic [SIDE_W-1:0]  rows_left_q;
	logic [LIN_W-1:0]   row_base_q;
	logic [BYTE_W-1:0]  lmask_q;
	logic [BYTE_W-1:0]  rmask_q;
	logic               single_q;

	// result holding
	logic [BYTE_W-1:0]  res_data_q;
	logic               res_clip_q;
	logic               rd_ok_q;
	logic               rsp_valid_q;
	logic [BYTE_W-1:0]  read_data_q;
	logic               clipped_q;

	// pending write stage
	logic               wr_s1;
	logic [AW-1:0]      waddr_s1;
	logic [BYTE_W-1:0]  wmask_s1;

	logic               req_acc;
	logic               sweep;
	logic               rsp_free;
	logic [BPR_W-1:0]   eff_stride;
	logic [LPX_W-1:0]   last_px;
	logic [FCOL_W-1:0]  acc_first_col;
	logic [LCOL_W-1:0]  acc_last_col;
	logic [LIN_W-1:0]   lin;
	logic               oob;
	logic [BYTE_W-1:0]  cur_mask;
	logic               last_col_hit;
	logic               rd_addr_ok;
	logic               mem_wr_en;
	logic [AW-1:0]      mem_wr_addr;
	logic [BYTE_W-1:0]  mem_wr_data;
	logic               mem_rd_en;
	logic [AW-1:0]      mem_rd_addr;
	logic [BYTE_W-1:0]  mem_rd_data;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign sweep     = (state_q == ST_INIT) || (state_q == ST_CLEAR);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;
	assign clipped   = clipped_q;

	// stride clamp
	always_comb begin
		if (bpr_q == '0) begin
			eff_stride = BPR_W'(1);
		end else if (bpr_q > STR_CLAMP) begin
			eff_stride = STR_CLAMP;
		end else begin
			eff_stride = bpr_q;
		end
	end

	// span of the new square
	assign last_px       = LPX_W'(x_pos) + LPX_W'(side) - LPX_W'(1);
	assign acc_first_col = x_pos[XPOS_W-1:3];
	assign acc_last_col  = last_px[LPX_W-1:3];
	assign rd_addr_ok    = (32'(byte_addr) < 32'(PLANE_BYTES));

	// current byte of the walk
	assign lin = row_base_q + LIN_W'(col_q);
	assign oob = (col_q >= LCOL_W'(stride_q)) || (row_q >= rows_q)
		|| (32'(lin) >= 32'(PLANE_BYTES));
	assign last_col_hit = (col_q == last_col_q);

	always_comb begin
		if (single_q) begin
			cur_mask = lmask_q & rmask_q;
		end else if (col_q == LCOL_W'(first_col_q)) begin
			cur_mask = lmask_q;
		end else if (last_col_hit) begin
			cur_mask = rmask_q;
		end else begin
			cur_mask = MASK_FULL;
		end
	end

	// memory port muxing
	always_comb begin
		mem_wr_en   = sweep || wr_s1;
		mem_wr_addr = sweep ? clr_q : waddr_s1;
		mem_wr_data = sweep ? '0 : (mem_rd_data | wmask_s1);
		mem_rd_en   = 1'b0;
		mem_rd_addr = AW'(byte_addr);
		if (req_acc && (cmd == CMD_READ) && rd_addr_ok) begin
			mem_rd_en = 1'b1;
		end else if ((state_q == ST_FILL) && !oob) begin
			mem_rd_en   = 1'b1;
			mem_rd_addr = AW'(lin);
		end
	end

	bsf_plane_ram #(
		.DEPTH (PLANE_BYTES)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpr_q  <= BPR_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BYTES_PER_ROW: bpr_q  <= cfg_data[BPR_W-1:0];
				REG_PLANE_ROWS:    rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clr_q       <= '0;
			wr_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			wr_s1 <= (state_q == ST_FILL) && !oob;
			// result beat raised from the response state, dropped once taken
			if ((state_q == ST_RESP) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					if (clr_q == LAST_ENTRY) begin
						clr_q   <= '0;
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_RESP;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						case (cmd)
							CMD_FILL:  state_q <= (side == '0) ? ST_RESP : ST_FILL;
							CMD_READ:  state_q <= ST_RDWAIT;
							CMD_CLEAR: state_q <= ST_CLEAR;
							default:   state_q <= ST_RESP;
						endcase
					end
				end
				ST_FILL: begin
					if (last_col_hit && (rows_left_q == SIDE_W'(1))) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_RESP;
				end
				ST_RDWAIT: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk and result payload
	always_ff @(posedge clk) begin
		waddr_s1 <= AW'(lin);
		wmask_s1 <= cur_mask;
		if (req_acc) begin
			stride_q    <= eff_stride;
			first_col_q <= acc_first_col;
			last_col_q  <= acc_last_col;
			col_q       <= LCOL_W'(acc_first_col);
			row_q       <= ROW_W'(y_pos);
			rows_left_q <= side;
			row_base_q  <= LIN_W'(y_pos) * LIN_W'(eff_stride);
			lmask_q     <= MASK_FULL >> x_pos[2:0];
			rmask_q     <= MASK_FULL << (3'd7 - last_px[2:0]);
			single_q    <= (LCOL_W'(acc_first_col) == acc_last_col);
			rd_ok_q     <= rd_addr_ok;
			res_data_q  <= '0;
			res_clip_q  <= 1'b0;
		end
		if (state_q == ST_FILL) begin
			if (oob) begin
				res_clip_q <= 1'b1;
			end
			if (last_col_hit) begin
				col_q       <= LCOL_W'(first_col_q);
				row_q       <= row_q + ROW_W'(1);
				rows_left_q <= rows_left_q - SIDE_W'(1);
				row_base_q  <= row_base_q + LIN_W'(stride_q);
			end else begin
				col_q <= col_q + LCOL_W'(1);
			end
		end
		// an address past the plane reads as zero
		if ((state_q == ST_RDWAIT) && rd_ok_q) begin
			res_data_q <= mem_rd_data;
		end
		if ((state_q == ST_RESP) && rsp_free) begin
			read_data_q <= res_data_q;
			clipped_q   <= res_clip_q;
		end
	end

	// a pending write never targets the byte being read in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_s1 && mem_rd_en) |-> (mem_rd_addr != waddr_s1))
		else $error("read and pending write hit the same plane byte");

	// no reads while the plane is being swept
	assert property (@(posedge clk) disable iff (!arst_n)
		sweep |-> !mem_rd_en)
		else $error("plane read during clearing sweep");

	// write-back only follows a fill read
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> ($past(state_q) == ST_FILL))
		else $error("write-back without a fill read");

	// every accepted beat leaves idle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q != ST_IDLE))
		else $error("accepted beat did not start work");

endmodule
